>>> hdl/pphd_pkg.sv
// shared constants, types and helper functions for the pid position h-bridge drive
// no dependencies; imported by every module of the block

package pphd_pkg;

  localparam int ADC_BITS_DEF      = 12;
  localparam int INTEGRAL_BITS_DEF = 48;

  localparam int GAIN_W      = 24;
  localparam int DT_W        = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_KP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KI = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KD = 2'd2;

  localparam logic [GAIN_W-1:0] KP_RESET = 24'd327680;
  localparam logic [GAIN_W-1:0] KI_RESET = 24'd3277;
  localparam logic [GAIN_W-1:0] KD_RESET = 24'd0;

  // derivative is scaled by 1000 before the divide
  localparam int DER_SCALE_W = 10;

  // integral term divide by 1000, quotient kept below the term limit
  localparam int KI_DIV   = 1000;
  localparam int KI_DIV_W = 10;
  localparam int KI_Q_W   = 40;

  localparam int TERM_MAG_W = 41;
  localparam int TERM_W     = 42;
  localparam int SUM_W      = 44;

  localparam logic [TERM_MAG_W-1:0] TERM_LIM = 41'h100_0000_0000;
  localparam logic signed [SUM_W-1:0] OUT_LIM = 44'sd16711680;

  localparam int FRAC_W   = 16;
  localparam int DUTY_W   = 8;
  localparam int CTRL_W   = 9;
  localparam int M_DATA_W = 32;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [TERM_MAG_W-1:0] sat_term(input logic [63:0] mag);
    logic [TERM_MAG_W-1:0] res;
    if (mag > 64'(TERM_LIM)) begin
      res = TERM_LIM;
    end else begin
      res = mag[TERM_MAG_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [TERM_W-1:0] signed_term(input logic neg,
                                                           input logic [TERM_MAG_W-1:0] mag);
    logic signed [TERM_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

endpackage

>>> hdl/pid_position_hbridge_drive_core.sv
// pid position controller with anti-windup driving two h-bridge pwm duties
// depends on pphd_pkg, pphd_mul and pphd_div
//
// One input beat is one control tick; it yields exactly one output beat. The datapath is
// bit serial: products are formed by shift-add multipliers and quotients by restoring
// dividers, one bit per cycle. A new tick is accepted only after the result of the last
// tick has been loaded into the output register. The tick length is set by the integral
// chain: an error times elapsed-time multiply, an integral times ki multiply and a divide
// by 1000, plus sequencer steps. The proportional and derivative paths run alongside
// and finish first. A finished result waits in the output register while the next tick
// is accepted. Gains are written through the cfg port; the user must write them only
// while the block is idle, as the block itself does not enforce it.

module pid_position_hbridge_drive_core #(
  parameter int ADC_BITS      = pphd_pkg::ADC_BITS_DEF,
  parameter int INTEGRAL_BITS = pphd_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  s_tvalid,
  output logic                                                  s_tready,
  // measured_position, elapsed_ms, new_target, zero pad
  input  logic [((2*ADC_BITS+pphd_pkg::DT_W+7)/8)*8-1:0]         s_tdata,
  // target_valid
  input  logic                                                  s_tuser,
  output logic                                                  m_tvalid,
  input  logic                                                  m_tready,
  // drive_cw, drive_ccw, control_value, zero pad
  output logic [pphd_pkg::M_DATA_W-1:0]                          m_tdata,
  // saturated
  output logic                                                  m_tuser,
  input  logic                                                  cfg_wen,
  input  logic [pphd_pkg::CFG_INDEX_W-1:0]                       cfg_index,
  input  logic [pphd_pkg::GAIN_W-1:0]                            cfg_data
);
  import pphd_pkg::*;

  localparam int EM_W  = ADC_BITS;
  localparam int E_W   = ADC_BITS + 1;
  localparam int DM_W  = ADC_BITS + 1;
  localparam int DIF_W = ADC_BITS + 2;
  localparam int DN_W  = DM_W + DER_SCALE_W;
  localparam int DP_W  = ADC_BITS + DT_W;
  localparam int IS_W  = ((INTEGRAL_BITS > DP_W + 1) ? INTEGRAL_BITS : DP_W + 1) + 1;
  localparam int KP_W  = EM_W + GAIN_W;
  localparam int KD_W  = DN_W + GAIN_W;
  localparam int KI_W  = INTEGRAL_BITS + GAIN_W;

  localparam logic signed [IS_W-1:0] IMAX =
    {{(IS_W-INTEGRAL_BITS+1){1'b0}}, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic signed [IS_W-1:0] IMIN = ~IMAX;
  localparam logic [KI_W-1:0] KI_SAT_LIM = KI_W'(KI_DIV) << KI_Q_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERR  = 3'd1;
  localparam logic [2:0] ST_DT   = 3'd2;
  localparam logic [2:0] ST_INT  = 3'd3;
  localparam logic [2:0] ST_KI   = 3'd4;
  localparam logic [2:0] ST_KDIV = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;

  logic [2:0] state;

  logic [GAIN_W-1:0] kp_gain;
  logic [GAIN_W-1:0] ki_gain;
  logic [GAIN_W-1:0] kd_gain;

  logic [ADC_BITS-1:0]             target;
  logic signed [E_W-1:0]           last_error;
  logic signed [INTEGRAL_BITS-1:0] integral;
  logic signed [INTEGRAL_BITS-1:0] int_new;

  logic [ADC_BITS-1:0] meas_r;
  logic [DT_W-1:0]     dt_r;
  logic                err_neg;
  logic                der_neg;
  logic                dt_zero;
  logic                kd_pending;
  logic                ki_sat;

  logic [DUTY_W-1:0] out_cw;
  logic [DUTY_W-1:0] out_ccw;
  logic [CTRL_W-1:0] out_ctrl;
  logic              out_sat;

  logic [ADC_BITS-1:0] s_meas;
  logic [DT_W-1:0]     s_dt;
  logic [ADC_BITS-1:0] s_tgt;

  logic signed [E_W-1:0]   err;
  logic signed [E_W-1:0]   err_abs;
  logic [EM_W-1:0]         err_mag;
  logic signed [DIF_W-1:0] diff;
  logic signed [DIF_W-1:0] diff_abs;
  logic [DM_W-1:0]         diff_mag;
  logic [DN_W-1:0]         der_num;

  logic signed [DP_W:0]            delta_pos;
  logic signed [DP_W:0]            delta;
  logic signed [IS_W-1:0]          int_sum;
  logic signed [INTEGRAL_BITS-1:0] int_clamped;
  logic signed [INTEGRAL_BITS-1:0] int_abs;

  logic [DP_W-1:0]     dt_prod;
  logic [KP_W-1:0]     kp_prod;
  logic [KI_W-1:0]     ki_prod;
  logic [KD_W-1:0]     kd_prod;
  logic [DN_W-1:0]     der_quot;
  logic [DN_W-1:0]     der_mag;
  logic [KI_Q_W-1:0]   ki_quot;

  unit_stat_t dt_stat;
  unit_stat_t kp_stat;
  unit_stat_t ki_stat;
  unit_stat_t kd_stat;
  unit_stat_t der_stat;
  unit_stat_t divk_stat;

  logic err_start;
  logic ki_start;
  logic divk_start;

  logic [TERM_MAG_W-1:0]   ki_mag;
  logic signed [TERM_W-1:0] t_kp;
  logic signed [TERM_W-1:0] t_ki;
  logic signed [TERM_W-1:0] t_kd;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_abs;
  logic                     sat_hi;
  logic                     sat_lo;
  logic                     ctrl_neg;
  logic [DUTY_W-1:0]        ctrl_mag;
  logic [CTRL_W-1:0]        ctrl_val;
  logic                     out_load;

  assign s_meas = s_tdata[ADC_BITS-1:0];
  assign s_dt   = s_tdata[ADC_BITS +: DT_W];
  assign s_tgt  = s_tdata[ADC_BITS+DT_W +: ADC_BITS];

  assign s_tready = (state == ST_IDLE);

  // error path
  always_comb begin
    err      = $signed({1'b0, target}) - $signed({1'b0, meas_r});
    err_abs  = err[E_W-1] ? -err : err;
    err_mag  = err_abs[EM_W-1:0];
    diff     = DIF_W'(err) - DIF_W'(last_error);
    diff_abs = diff[DIF_W-1] ? -diff : diff;
    diff_mag = diff_abs[DM_W-1:0];
    // x * 1000 as x * 1024 - x * 16 - x * 8
    der_num  = (DN_W'(diff_mag) << DER_SCALE_W) - (DN_W'(diff_mag) << 4)
             - (DN_W'(diff_mag) << 3);
  end

  // saturating integral update
  always_comb begin
    delta_pos = $signed({1'b0, dt_prod});
    delta     = err_neg ? -delta_pos : delta_pos;
    int_sum   = IS_W'(integral) + IS_W'(delta);
    if (int_sum > IMAX) begin
      int_clamped = IMAX[INTEGRAL_BITS-1:0];
    end else if (int_sum < IMIN) begin
      int_clamped = IMIN[INTEGRAL_BITS-1:0];
    end else begin
      int_clamped = int_sum[INTEGRAL_BITS-1:0];
    end
    int_abs = int_new[INTEGRAL_BITS-1] ? -int_new : int_new;
  end

  assign err_start  = (state == ST_ERR);
  assign ki_start   = (state == ST_INT);
  assign divk_start = (state == ST_KI) && ki_stat.done;
  assign der_mag    = dt_zero ? '0 : der_quot;

  pphd_mul #(.A_W(EM_W), .B_W(DT_W)) u_mul_dt (
    .clk(clk), .rst(rst), .start(err_start), .a(err_mag), .b(dt_r),
    .product(dt_prod), .stat(dt_stat)
  );

  pphd_mul #(.A_W(EM_W), .B_W(GAIN_W)) u_mul_kp (
    .clk(clk), .rst(rst), .start(err_start), .a(err_mag), .b(kp_gain),
    .product(kp_prod), .stat(kp_stat)
  );

  pphd_div #(.N_W(DN_W), .D_W(DT_W)) u_div_der (
    .clk(clk), .rst(rst), .start(err_start), .num(der_num), .rem0('0), .den(dt_r),
    .quot(der_quot), .stat(der_stat)
  );

  pphd_mul #(.A_W(DN_W), .B_W(GAIN_W)) u_mul_kd (
    .clk(clk), .rst(rst), .start(der_stat.done), .a(der_mag), .b(kd_gain),
    .product(kd_prod), .stat(kd_stat)
  );

  pphd_mul #(.A_W(INTEGRAL_BITS), .B_W(GAIN_W)) u_mul_ki (
    .clk(clk), .rst(rst), .start(ki_start), .a($unsigned(int_abs)), .b(ki_gain),
    .product(ki_prod), .stat(ki_stat)
  );

  pphd_div #(.N_W(KI_Q_W), .D_W(KI_DIV_W)) u_div_ki (
    .clk(clk), .rst(rst), .start(divk_start),
    .num(ki_prod[KI_Q_W-1:0]), .rem0(ki_prod[KI_Q_W+KI_DIV_W-1:KI_Q_W]),
    .den(KI_DIV_W'(KI_DIV)), .quot(ki_quot), .stat(divk_stat)
  );

  // control sum and clamp
  always_comb begin
    ki_mag   = ki_sat ? TERM_LIM : TERM_MAG_W'(ki_quot);
    t_kp     = signed_term(err_neg, sat_term(64'(kp_prod)));
    t_ki     = signed_term(int_new[INTEGRAL_BITS-1], ki_mag);
    t_kd     = signed_term(der_neg, sat_term(64'(kd_prod)));
    sum      = SUM_W'(t_kp) + SUM_W'(t_ki) + SUM_W'(t_kd);
    sat_hi   = sum > OUT_LIM;
    sat_lo   = sum < -OUT_LIM;
    sum_abs  = sum[SUM_W-1] ? -sum : sum;
    ctrl_neg = sum[SUM_W-1];
    ctrl_mag = (sat_hi || sat_lo) ? DUTY_MAX : sum_abs[FRAC_W +: DUTY_W];
    ctrl_val = ctrl_neg ? -{1'b0, ctrl_mag} : {1'b0, ctrl_mag};
  end

  assign out_load = (state == ST_SUM) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain <= KP_RESET;
      ki_gain <= KI_RESET;
      kd_gain <= KD_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_KP: kp_gain <= cfg_data;
        REG_KI: ki_gain <= cfg_data;
        REG_KD: kd_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      kd_pending <= 1'b0;
      target     <= '0;
      last_error <= '0;
      integral   <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (kd_stat.done) begin
        kd_pending <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser && (s_tgt != '0)) begin
              target <= s_tgt;
            end
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          last_error <= err;
          kd_pending <= 1'b1;
          state      <= ST_DT;
        end
        ST_DT: begin
          if (dt_stat.done) begin
            state <= ST_INT;
          end
        end
        ST_INT: state <= ST_KI;
        ST_KI: begin
          if (ki_stat.done) begin
            state <= ST_KDIV;
          end
        end
        ST_KDIV: begin
          if (!divk_stat.busy && !kd_pending) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_load) begin
            // anti-windup: a clamped tick keeps the old integral
            if (!(sat_hi || sat_lo)) begin
              integral <= int_new;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && s_tvalid) begin
      meas_r <= s_meas;
      dt_r   <= s_dt;
    end
    if (state == ST_ERR) begin
      err_neg <= err[E_W-1];
      der_neg <= diff[DIF_W-1];
      dt_zero <= (dt_r == '0);
    end
    if ((state == ST_DT) && dt_stat.done) begin
      int_new <= int_clamped;
    end
    if (divk_start) begin
      ki_sat <= (ki_prod >= KI_SAT_LIM);
    end
    if (out_load) begin
      out_cw   <= ctrl_neg ? ctrl_mag : '0;
      out_ccw  <= ctrl_neg ? '0 : ctrl_mag;
      out_ctrl <= ctrl_val;
      out_sat  <= sat_hi || sat_lo;
    end
  end

  assign m_tdata = M_DATA_W'({out_ctrl, out_ccw, out_cw});
  assign m_tuser = out_sat;

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!ki_stat.busy && !divk_stat.busy && !kd_stat.busy && !kp_stat.busy))
    else $error("serial units still busy while accepting a tick");

  a_one_tick_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second tick accepted while one is in progress");

  a_single_channel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[DUTY_W-1:0] == '0) || (m_tdata[2*DUTY_W-1:DUTY_W] == '0)))
    else $error("both drive channels nonzero");

  a_sat_full_duty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      ((m_tdata[DUTY_W-1:0] == DUTY_MAX) || (m_tdata[2*DUTY_W-1:DUTY_W] == DUTY_MAX)))
    else $error("saturated beat without full duty");

endmodule

>>> hdl/pphd_mul.sv
// shift-add unsigned multiplier, one multiplier bit per cycle
// depends on pphd_pkg for the unit status struct

module pphd_mul #(
  parameter int A_W = 16,
  parameter int B_W = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [A_W-1:0]         a,
  input  logic [B_W-1:0]         b,
  output logic [A_W+B_W-1:0]     product,
  output pphd_pkg::unit_stat_t   stat
);
  import pphd_pkg::*;

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   mcand;
  logic [A_W-1:0]   acc;
  logic [B_W-1:0]   mplier;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [A_W:0]     partial;

  assign partial = {1'b0, acc} + (mplier[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mplier <= b;
      mcand  <= a;
    end else if (busy) begin
      acc    <= partial[A_W:1];
      mplier <= {partial[0], mplier[B_W-1:1]};
    end
  end

  assign product   = {acc, mplier};
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> hdl/pphd_div.sv
// restoring divider, one quotient bit per cycle, with a preset partial remainder
// depends on pphd_pkg for the unit status struct

module pphd_div #(
  parameter int N_W = 23,
  parameter int D_W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [N_W-1:0]       num,
  input  logic [D_W-1:0]       rem0,
  input  logic [D_W-1:0]       den,
  output logic [N_W-1:0]       quot,
  output pphd_pkg::unit_stat_t stat
);
  import pphd_pkg::*;

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dreg;
  logic [N_W-1:0]   q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;
  logic             ge;

  assign shifted = {rem, q[N_W-1]};
  assign ge      = shifted >= {1'b0, dreg};
  assign trial   = shifted - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem0;
      dreg <= den;
      q    <= num;
    end else if (busy) begin
      rem <= ge ? trial[D_W-1:0] : shifted[D_W-1:0];
      q   <= {q[N_W-2:0], ge};
    end
  end

  assign quot      = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> tb/pid_position_hbridge_drive_core_tb.sv
// self-checking testbench for the pid position h-bridge drive core
// depends on pphd_pkg and pid_position_hbridge_drive_core; predicts each control tick
// in place and checks every output beat against it under random idling and backpressure
`timescale 1ns / 1ps

module pid_position_hbridge_drive_core_tb;
  import pphd_pkg::*;

  localparam int S_DATA_W = 40;
  localparam int STALL_LIMIT = 5000;
  localparam longint INTEG_MAX = (longint'(1) << 47) - 1;
  localparam longint INTEG_MIN = -(longint'(1) << 47);
  localparam longint unsigned TERM_CAP = 64'd1 << 40;
  localparam longint OUT_CAP = 255 * 65536;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFFFFFF;

  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_SPARSE} rdy_mode_t;

  typedef struct packed {
    logic [7:0]        cw;
    logic [7:0]        ccw;
    logic signed [8:0] ctrl;
    logic              sat;
  } drive_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_DATA_W-1:0]    m_tdata;
  logic                   m_tuser;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]      cfg_data;

  // predictor copy of gains and controller state
  logic [GAIN_W-1:0] kp_set, ki_set, kd_set;
  logic [11:0]       tgt_pos;
  longint            prev_err;
  longint            err_int;

  drive_t    drive_q[$];
  int        err_count;
  int        burst_left;
  bit        no_gaps;
  int        hold_left;
  rdy_mode_t ready_mode;

  pid_position_hbridge_drive_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // trunc0(a * g / div) with magnitude capped at 2^40, sign kept
  function automatic longint scale_sat(input longint a, input logic [GAIN_W-1:0] g,
                                       input longint unsigned div);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag = (a < 0) ? -a : a;
    prod = {64'd0, mag} * {104'd0, g};
    if (prod > 128'hFFFF_FFFF_FFFF_FFFF) begin
      prod = 128'(TERM_CAP);
    end else begin
      prod = prod / 128'(div);
      if (prod > 128'(TERM_CAP)) prod = 128'(TERM_CAP);
    end
    return (a < 0) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  function automatic drive_t predict_tick(input logic [11:0] meas, input logic [15:0] elapsed,
                                          input logic tv, input logic [11:0] tgt);
    longint err, dt, delta, old_int, deriv, sum, ctrl;
    int     tp, ms;
    drive_t r;
    if (tv && tgt != 0) tgt_pos = tgt;
    tp = int'(tgt_pos);
    ms = int'(meas);
    dt = longint'(elapsed);
    err = longint'(tp - ms);
    old_int = err_int;
    delta = err * dt;
    if (delta > 0 && err_int > INTEG_MAX - delta) err_int = INTEG_MAX;
    else if (delta < 0 && err_int < INTEG_MIN - delta) err_int = INTEG_MIN;
    else err_int = err_int + delta;
    deriv = (dt != 0) ? ((err - prev_err) * 1000) / dt : 0;
    sum = scale_sat(err, kp_set, 1) + scale_sat(err_int, ki_set, 1000)
        + scale_sat(deriv, kd_set, 1);
    prev_err = err;
    r.sat = 1'b1;
    if (sum > OUT_CAP) begin
      ctrl = 255;
    end else if (sum < -OUT_CAP) begin
      ctrl = -255;
    end else begin
      ctrl = sum / 65536;
      r.sat = 1'b0;
    end
    if (r.sat) err_int = old_int;
    r.cw = (ctrl < 0) ? 8'(-ctrl) : 8'd0;
    r.ccw = (ctrl < 0) ? 8'd0 : 8'(ctrl);
    r.ctrl = 9'(ctrl);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  task automatic send_tick(input logic [11:0] meas, input logic [15:0] elapsed,
                           input logic tv, input logic [11:0] tgt);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 120);
      burst_left = $urandom_range(1, 10);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata <= {tgt, elapsed, meas};
    s_tuser <= tv;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    drive_q.push_back(predict_tick(meas, elapsed, tv, tgt));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_index <= REG_KP;
    cfg_data <= kp;
    @(posedge clk);
    cfg_index <= REG_KI;
    cfg_data <= ki;
    @(posedge clk);
    cfg_index <= REG_KD;
    cfg_data <= kd;
    @(posedge clk);
    cfg_wen <= 1'b0;
    kp_set = kp;
    ki_set = ki;
    kd_set = kd;
  endtask

  task automatic test_default_gains();
    ready_mode = RDY_RANDOM;
    send_tick(12'd0, 16'd1, 1'b1, 12'd4095);
    send_tick(12'd4095, 16'd65535, 1'b1, 12'd0);
    send_tick(12'd4090, 16'd10, 1'b0, 12'd100);
    send_tick(12'd4095, 16'd0, 1'b1, 12'd2048);
    send_tick(12'd2050, 16'd20, 1'b1, 12'd2048);
    send_tick(12'd2048, 16'd1, 1'b0, 12'd4095);
    send_tick(12'd2046, 16'd65535, 1'b0, 12'd0);
  endtask

  task automatic test_gain_extremes();
    set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
    send_tick(12'd0, 16'd1, 1'b1, 12'd4095);
    send_tick(12'd4095, 16'd65535, 1'b0, 12'd0);
    send_tick(12'd4095, 16'd0, 1'b1, 12'd1);
    set_gains(24'd0, 24'd0, 24'd0);
    send_tick(12'd0, 16'd300, 1'b1, 12'd3000);
    send_tick(12'd4095, 16'd0, 1'b0, 12'd0);
    // derivative alone, truncation of odd quotients in both directions
    set_gains(24'd0, 24'd0, 24'd65536);
    send_tick(12'd3007, 16'd3, 1'b0, 12'd0);
    send_tick(12'd2990, 16'd7, 1'b0, 12'd0);
    send_tick(12'd3001, 16'd65535, 1'b0, 12'd0);
    // gain just under one, truncation toward zero of negative control
    set_gains(24'd65535, 24'd0, 24'd0);
    send_tick(12'd3003, 16'd5, 1'b0, 12'd0);
    send_tick(12'd2997, 16'd5, 1'b0, 12'd0);
  endtask

  task automatic test_random_ticks();
    logic [GAIN_W-1:0] g[3];
    int                tp, m, pick;
    logic [15:0]       dt;
    logic [11:0]       tgt;
    for (int phase = 0; phase < 8; phase++) begin
      pick = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        case (pick)
          0: g[i] = 24'($urandom_range(0, (i == 0) ? 8 * 65536 : (i == 1) ? 65536 : 4096));
          1: g[i] = 24'($urandom_range(0, 32'(GAIN_MAX)));
          default: g[i] = ($urandom_range(0, 2) == 0) ? 24'd0 :
                          ($urandom_range(0, 1) == 0) ? GAIN_MAX : 24'($urandom);
        endcase
      end
      set_gains(g[0], g[1], g[2]);
      ready_mode = rdy_mode_t'(phase % 4);
      no_gaps = (phase == 2);
      for (int n = 0; n < 100; n++) begin
        tp = int'(tgt_pos);
        if ($urandom_range(0, 1) == 0) begin
          m = $urandom_range(0, 80);
          m = m + tp - 40;
          if (m < 0) m = 0;
          if (m > 4095) m = 4095;
        end else begin
          m = $urandom_range(0, 4095);
        end
        pick = $urandom_range(0, 99);
        dt = (pick < 70) ? 16'($urandom_range(1, 100)) :
             (pick < 98) ? 16'($urandom_range(1, 65535)) : 16'd0;
        tgt = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
        send_tick(12'(m), dt, ($urandom_range(0, 3) == 0), tgt);
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    ready_mode = RDY_ALWAYS;
    no_gaps = 1'b1;
    hold_left = 600;
    for (int n = 0; n < 12; n++)
      send_tick(12'($urandom_range(0, 4095)), 16'($urandom_range(1, 200)), 1'b0, 12'd0);
    no_gaps = 1'b0;
  endtask

  task automatic test_integral_windup();
    set_gains(24'd0, 24'd0, 24'd0);
    ready_mode = RDY_ALWAYS;
    no_gaps = 1'b1;
    // grow the integral until ki times integral saturates its term
    for (int n = 0; n < 150; n++)
      send_tick(12'd0, 16'd65535, 1'b1, 12'd4095);
    set_gains(24'd65536, GAIN_MAX, GAIN_MAX);
    send_tick(12'd0, 16'd65535, 1'b0, 12'd0);
    send_tick(12'd4095, 16'd1, 1'b0, 12'd0);
    set_gains(24'd0, 24'd1, 24'd0);
    send_tick(12'd4095, 16'd65535, 1'b0, 12'd0);
    send_tick(12'd2000, 16'd0, 1'b0, 12'd0);
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin : check_beats
    drive_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (drive_q.size() == 0) begin
        $display("%0t: output beat with nothing expected, actual %h", $time, m_tdata);
        err_count++;
      end else begin
        want = drive_q.pop_front();
        check_field("drive_cw", int'(want.cw), int'(m_tdata[7:0]));
        check_field("drive_ccw", int'(want.ccw), int'(m_tdata[15:8]));
        check_field("control_value", int'(want.ctrl), int'($signed(m_tdata[24:16])));
        check_field("saturated", int'(want.sat), int'(m_tuser));
      end
    end
  end

  initial begin : receiver
    int cyc;
    m_tready = 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        case (ready_mode)
          RDY_ALWAYS:   m_tready <= 1'b1;
          RDY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
          RDY_PERIODIC: m_tready <= ((cyc % 7) < 3);
          default:      m_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_wen = 1'b0;
    cfg_index = REG_KP;
    cfg_data = '0;
    kp_set = KP_RESET;
    ki_set = KI_RESET;
    kd_set = KD_RESET;
    tgt_pos = '0;
    prev_err = 0;
    err_int = 0;
    err_count = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_left = 0;
    ready_mode = RDY_ALWAYS;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_gains();
    test_gain_extremes();
    test_random_ticks();
    test_backpressure();
    test_integral_windup();

    wait_drained();
    repeat (100) @(posedge clk);
    if (err_count == 0 && drive_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pphd_pkg.sv
hdl/pphd_mul.sv
hdl/pphd_div.sv
hdl/pid_position_hbridge_drive_core.sv
tb/pid_position_hbridge_drive_core_tb.sv
